// ===== sv/phh_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse-height histogram package
// Beat types, request codes, state encoding and search constants shared by
// the histogram blocks.
// ----------------------------------------------------------------------------
package phh_pkg;

  localparam int DEF_NUM_BINS     = 16384;
  localparam int DEF_NUM_CHANNELS = 4;
  localparam int DEF_COUNT_BITS   = 32;

  localparam int STEP          = 10;
  localparam int HALF_STEP     = 5;
  localparam int WIN_LEN       = 15;
  localparam int RUN_TH        = 5;
  localparam int PEAK_FRAC     = 20;
  localparam int PEAK_BIN_BITS = 15;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  channel;
    logic [15:0] adc_value;
  } in_item_t;

  typedef struct packed {
    logic [PEAK_BIN_BITS-1:0] peak_bin;
    logic                     from_fallback;
    logic                     last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_MAX,
    S_MAX_END,
    S_WIN,
    S_WIN_END,
    S_EVAL,
    S_PEAK_RD,
    S_PEAK_CMP,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SLOPE_ZERO,
    SLOPE_UP,
    SLOPE_DOWN
  } slope_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_MAX,
    RD_WIN
  } rdk_t;

endpackage

// ===== sv/phh_hist_ram.sv =====
// ----------------------------------------------------------------------------
// Histogram count memory
// Single-port-write, single-port-read synchronous RAM with
// registered read data.
// ----------------------------------------------------------------------------
module phh_hist_ram #(
  parameter int  DEPTH     = phh_pkg::DEF_NUM_CHANNELS * phh_pkg::DEF_NUM_BINS,
  parameter int  DATA_BITS = phh_pkg::DEF_COUNT_BITS,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pulse_height_histogram_peak_search.sv =====
// ----------------------------------------------------------------------------
// Pulse-height histogram with peak search
// Add beats: a read, then a saturating write back through the RAM.
// Search beats: a maximum scan over all NUM_BINS bins, then a window sum per
//   step plus a peak check read per run hit, one RAM read per cycle; then 1-2 results.
// Clear beats and reset: a zeroing sweep of all NUM_CHANNELS*2^clog2(NUM_BINS)
//   RAM entries (65536 by default), one entry per cycle, no beat accepted.
// ----------------------------------------------------------------------------
module pulse_height_histogram_peak_search #(
  parameter int NUM_BINS     = phh_pkg::DEF_NUM_BINS,
  parameter int NUM_CHANNELS = phh_pkg::DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = phh_pkg::DEF_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  phh_pkg::in_item_t  req_data,
  output logic               res_valid,
  input  logic               res_stall,
  output phh_pkg::out_item_t res_data
);

  import phh_pkg::*;

  localparam int BIN_BITS  = $clog2(NUM_BINS);
  localparam int BNUM_BITS = BIN_BITS + 1;
  localparam int MEM_DEPTH = NUM_CHANNELS << BIN_BITS;
  localparam int ADDR_BITS = $clog2(MEM_DEPTH);
  localparam int SUM_BITS  = COUNT_BITS + 4;
  localparam int PROD_BITS = COUNT_BITS + 5;
  localparam int RUN_BITS  = $clog2(RUN_TH + 1);
  localparam int K_BITS    = $clog2(WIN_LEN);

  state_t state, state_next;

  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic [COUNT_BITS-1:0] mem_rdata;

  logic [ADDR_BITS-1:0]  clr_addr;
  logic [ADDR_BITS-1:0]  add_addr;
  logic [1:0]            ch_sel;
  logic                  ch_ok;
  logic [BIN_BITS-1:0]   idx;
  logic [BNUM_BITS-1:0]  scan_b;
  logic [BNUM_BITS-1:0]  peak_pos;
  logic [BNUM_BITS-1:0]  peak0;
  logic [BNUM_BITS-1:0]  peak1;
  logic [BNUM_BITS-1:0]  max_bin;
  logic [COUNT_BITS-1:0] max_cnt;
  logic [K_BITS-1:0]     win_k;
  logic [SUM_BITS-1:0]   win_sum;
  logic [SUM_BITS-1:0]   prev_sum;
  slope_t                prev_slope;
  logic [RUN_BITS-1:0]   up_cnt;
  logic [RUN_BITS-1:0]   down_cnt;
  logic [1:0]            npk;
  logic                  emit_sel;
  rdk_t                  rd_kind;
  rdk_t                  issue_kind;
  logic [BNUM_BITS-1:0]  rd_bin;

  logic                  req_take;
  logic                  req_ch_ok;
  logic                  adc_ok;
  logic [1:0]            req_ch;
  logic [ADDR_BITS-1:0]  req_addr;
  logic                  clr_done;
  logic [COUNT_BITS-1:0] rd_val;
  logic [COUNT_BITS-1:0] sat_inc;
  logic [BIN_BITS-1:0]   win_bin;
  logic [BIN_BITS-1:0]   peak_rd_bin;

  slope_t                slope;
  logic [RUN_BITS-1:0]   up_a;
  logic [RUN_BITS-1:0]   up_b;
  logic [RUN_BITS-1:0]   down_b;
  logic                  run_hit;
  logic [BNUM_BITS-1:0]  pos_next;
  logic                  pos_ok;
  logic                  step_more;
  logic [PROD_BITS-1:0]  peak_prod;
  logic                  peak_take;

  logic [BNUM_BITS-1:0]  emit_bin;
  logic [31:0]           emit_bin32;
  logic                  emit_fb;
  logic                  emit_last;
  logic                  res_free;
  logic                  res_load;
  out_item_t             emit_item;

  phh_hist_ram #(
    .DEPTH    (MEM_DEPTH),
    .DATA_BITS(COUNT_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign req_ch_ok = 5'(req_data.channel) < 5'(NUM_CHANNELS);
  assign adc_ok    = 17'(req_data.adc_value) < 17'(NUM_BINS);
  assign req_ch    = req_ch_ok ? req_data.channel : 2'd0;
  assign req_addr  = ADDR_BITS'({req_ch, BIN_BITS'(req_data.adc_value)});
  assign clr_done  = (clr_addr == ADDR_BITS'(MEM_DEPTH - 1));

  assign rd_val  = ch_ok ? mem_rdata : '0;
  assign sat_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_BITS'(1);

  assign win_bin     = BIN_BITS'(scan_b - BNUM_BITS'(HALF_STEP + 1) + BNUM_BITS'(win_k));
  assign peak_rd_bin = BIN_BITS'(peak_pos - BNUM_BITS'(1));

  assign pos_next  = scan_b + BNUM_BITS'(RUN_TH * STEP);
  assign pos_ok    = pos_next <= BNUM_BITS'(NUM_BINS);
  assign step_more = scan_b > BNUM_BITS'(2 * STEP);

  assign peak_prod = PROD_BITS'(rd_val) * PROD_BITS'(PEAK_FRAC);
  assign peak_take = peak_prod > PROD_BITS'(max_cnt);

  always_comb begin
    if (win_sum > prev_sum) begin
      slope = SLOPE_UP;
    end else if (win_sum < prev_sum) begin
      slope = SLOPE_DOWN;
    end else begin
      slope = SLOPE_ZERO;
    end
    if (up_cnt < RUN_BITS'(RUN_TH) && slope == SLOPE_DOWN && prev_slope == SLOPE_DOWN) begin
      up_a = '0;
    end else begin
      up_a = up_cnt;
    end
    up_b   = up_a;
    down_b = down_cnt;
    if (slope != SLOPE_ZERO && slope == prev_slope) begin
      if (up_a != '0 && slope == SLOPE_DOWN) begin
        down_b = (down_cnt >= RUN_BITS'(RUN_TH)) ? down_cnt : down_cnt + RUN_BITS'(1);
      end else if (slope == SLOPE_UP) begin
        up_b = (up_a >= RUN_BITS'(RUN_TH)) ? up_a : up_a + RUN_BITS'(1);
      end
    end
    run_hit = (up_b >= RUN_BITS'(RUN_TH)) && (down_b >= RUN_BITS'(RUN_TH));
  end

  always_comb begin
    if (npk == 2'd0) begin
      emit_bin  = max_bin;
      emit_fb   = 1'b1;
      emit_last = 1'b1;
    end else if (!emit_sel) begin
      emit_bin  = peak0;
      emit_fb   = 1'b0;
      emit_last = (npk == 2'd1);
    end else begin
      emit_bin  = peak1;
      emit_fb   = 1'b0;
      emit_last = 1'b1;
    end
    emit_bin32 = 32'(emit_bin);
    emit_item  = '{peak_bin: emit_bin32[PEAK_BIN_BITS-1:0],
                   from_fallback: emit_fb,
                   last: emit_last};
  end

  assign res_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = add_addr;
    mem_wdata  = sat_inc;
    mem_raddr  = '0;
    issue_kind = RD_NONE;
    res_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = req_addr;
        if (req_take) begin
          unique case (req_data.req_type)
            REQ_ADD: begin
              if (req_ch_ok && adc_ok) begin
                state_next = S_ADD;
              end
            end
            REQ_SEARCH: state_next = S_MAX;
            REQ_CLEAR:  state_next = S_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        mem_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_MAX: begin
        mem_raddr  = ADDR_BITS'({ch_sel, idx});
        issue_kind = RD_MAX;
        if (idx == BIN_BITS'(NUM_BINS - 1)) begin
          state_next = S_MAX_END;
        end
      end
      S_MAX_END: state_next = S_WIN;
      S_WIN: begin
        mem_raddr  = ADDR_BITS'({ch_sel, win_bin});
        issue_kind = RD_WIN;
        if (win_k == K_BITS'(WIN_LEN - 1)) begin
          state_next = S_WIN_END;
        end
      end
      S_WIN_END: state_next = S_EVAL;
      S_EVAL: begin
        if (run_hit && pos_ok) begin
          state_next = S_PEAK_RD;
        end else if (step_more) begin
          state_next = S_WIN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_PEAK_RD: begin
        mem_raddr  = ADDR_BITS'({ch_sel, peak_rd_bin});
        state_next = S_PEAK_CMP;
      end
      S_PEAK_CMP: begin
        if (peak_take && npk == 2'd1) begin
          state_next = S_EMIT;
        end else if (step_more) begin
          state_next = S_WIN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_free) begin
          res_load = 1'b1;
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_done ? '0 : clr_addr + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    rd_kind <= issue_kind;
    rd_bin  <= BNUM_BITS'(idx) + BNUM_BITS'(1);

    if (state == S_IDLE && req_take) begin
      add_addr   <= req_addr;
      ch_sel     <= req_ch;
      ch_ok      <= req_ch_ok;
      idx        <= '0;
      max_cnt    <= '0;
      max_bin    <= BNUM_BITS'(1);
      scan_b     <= BNUM_BITS'(NUM_BINS - STEP);
      win_k      <= '0;
      win_sum    <= '0;
      prev_sum   <= '0;
      prev_slope <= SLOPE_ZERO;
      up_cnt     <= '0;
      down_cnt   <= '0;
      npk        <= 2'd0;
      emit_sel   <= 1'b0;
    end

    if (state == S_MAX) begin
      idx <= idx + BIN_BITS'(1);
    end

    if (rd_kind == RD_MAX && rd_val > max_cnt) begin
      max_cnt <= rd_val;
      max_bin <= rd_bin;
    end

    if (rd_kind == RD_WIN) begin
      win_sum <= win_sum + SUM_BITS'(rd_val);
    end

    if (state == S_WIN) begin
      win_k <= (win_k == K_BITS'(WIN_LEN - 1)) ? '0 : win_k + K_BITS'(1);
    end

    if (state == S_EVAL) begin
      prev_sum   <= win_sum;
      prev_slope <= slope;
      win_sum    <= '0;
      peak_pos   <= pos_next;
      if (run_hit) begin
        up_cnt   <= '0;
        down_cnt <= '0;
      end else begin
        up_cnt   <= up_b;
        down_cnt <= down_b;
      end
      if (!(run_hit && pos_ok)) begin
        scan_b <= scan_b - BNUM_BITS'(STEP);
      end
    end

    if (state == S_PEAK_CMP) begin
      scan_b <= scan_b - BNUM_BITS'(STEP);
      if (peak_take) begin
        if (npk == 2'd0) begin
          peak0 <= peak_pos;
        end else begin
          peak1 <= peak_pos;
        end
        npk <= npk + 2'd1;
      end
    end

    if (res_load) begin
      emit_sel <= 1'b1;
    end
  end

endmodule

// ===== verif/phh_peak_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak search scoreboard
// Keeps its own copy of every channel histogram, works out the peak or
// maximum-bin beats that each search beat must give, and checks the result
// beats of the block against them in order.
// ----------------------------------------------------------------------------
package phh_peak_scoreboard_pkg;
  import phh_pkg::*;

  localparam int NUM_BINS     = DEF_NUM_BINS;
  localparam int NUM_CHANNELS = DEF_NUM_CHANNELS;
  localparam int COUNT_BITS   = DEF_COUNT_BITS;
  localparam int MAX_PEAKS    = 2;

  localparam logic [1:0] REQ_NONE = 2'd3;

  class peak_scoreboard;
    bit [COUNT_BITS-1:0] counts [NUM_CHANNELS*NUM_BINS];
    out_item_t           expected_peaks [$];
    int errors;
    int n_adds, n_dropped, n_ignored, n_searches, n_clears;
    int n_peaks, n_fallbacks;

    function longint unsigned count_at(logic [1:0] ch, int b);
      if (int'(ch) >= NUM_CHANNELS || b < 1 || b > NUM_BINS) return 0;
      return counts[int'(ch) * NUM_BINS + b - 1];
    endfunction

    function void note_request(in_item_t item);
      longint unsigned maxc;
      longint          sum;
      longint          prev_sum;
      int              maxbin, up, down, npk, b, i, k;
      int              peak_bins [MAX_PEAKS];
      slope_t          slope, prev_slope;
      out_item_t       res;
      case (item.req_type)
        REQ_ADD: begin
          if (item.adc_value >= NUM_BINS || int'(item.channel) >= NUM_CHANNELS) begin
            n_dropped++;
          end else begin
            n_adds++;
            i = int'(item.channel) * NUM_BINS + int'(item.adc_value);
            if (counts[i] != '1) counts[i]++;
          end
        end
        REQ_CLEAR: begin
          n_clears++;
          foreach (counts[j]) counts[j] = '0;
        end
        REQ_SEARCH: begin
          n_searches++;
          maxc   = 0;
          maxbin = 1;
          for (b = 1; b <= NUM_BINS; b++) begin
            if (count_at(item.channel, b) > maxc) begin
              maxc   = count_at(item.channel, b);
              maxbin = b;
            end
          end
          prev_sum   = 0;
          prev_slope = SLOPE_ZERO;
          up         = 0;
          down       = 0;
          npk        = 0;
          for (b = NUM_BINS - STEP; b - STEP > 0 && npk < MAX_PEAKS; b -= STEP) begin
            sum = 0;
            for (i = b - HALF_STEP; i < b - HALF_STEP + WIN_LEN; i++)
              sum += count_at(item.channel, i);
            slope = (sum > prev_sum) ? SLOPE_UP : ((sum < prev_sum) ? SLOPE_DOWN : SLOPE_ZERO);
            prev_sum = sum;
            if (up < RUN_TH && slope == SLOPE_DOWN && prev_slope == SLOPE_DOWN) up = 0;
            if (slope != SLOPE_ZERO && slope == prev_slope) begin
              if (up > 0 && slope == SLOPE_DOWN) down++;
              else if (slope == SLOPE_UP) up++;
            end
            prev_slope = slope;
            if (up >= RUN_TH && down >= RUN_TH) begin
              up   = 0;
              down = 0;
              if (count_at(item.channel, b + RUN_TH * STEP) * PEAK_FRAC > maxc) begin
                peak_bins[npk] = b + RUN_TH * STEP;
                npk++;
              end
            end
          end
          if (npk == 0) begin
            res.peak_bin      = maxbin[PEAK_BIN_BITS-1:0];
            res.from_fallback = 1'b1;
            res.last          = 1'b1;
            expected_peaks = {expected_peaks, res};
            n_fallbacks++;
          end else begin
            for (k = 0; k < npk; k++) begin
              res.peak_bin      = peak_bins[k][PEAK_BIN_BITS-1:0];
              res.from_fallback = 1'b0;
              res.last          = (k == npk - 1);
              expected_peaks = {expected_peaks, res};
              n_peaks++;
            end
          end
        end
        default: begin
          n_ignored++;
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_peaks.size() == 0) begin
        $error("result beat with no search pending: peak_bin %0d from_fallback %0b last %0b",
               got.peak_bin, got.from_fallback, got.last);
        errors++;
        return;
      end
      want = expected_peaks.pop_front();
      if (got.peak_bin !== want.peak_bin) begin
        $error("peak_bin mismatch: expected %0d, actual %0d", want.peak_bin, got.peak_bin);
        errors++;
      end
      if (got.from_fallback !== want.from_fallback) begin
        $error("from_fallback mismatch: expected %0b, actual %0b",
               want.from_fallback, got.from_fallback);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== verif/pulse_height_histogram_peak_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse-height histogram peak search testbench
// Drives add, search, clear and unused request beats with random gaps and
// result stalls, builds peak-shaped histograms so that searches find peaks,
// and checks every result beat against a scoreboard that mirrors the
// histograms and redoes each search.
// ----------------------------------------------------------------------------
module pulse_height_histogram_peak_search_tb;
  import phh_pkg::*;
  import phh_peak_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT       = 12_000_000;
  localparam int ITEM_TARGET       = 1750;
  localparam int HOLD_CYCLES       = 50_000;
  localparam int MAX_RANDOM_CLEARS = 3;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  in_item_t  req_data;
  logic      res_valid;
  logic      res_stall;
  out_item_t res_data;

  peak_scoreboard peak_check = new();
  int             tx_run;
  int             rx_run;
  int             cycles;
  bit             hold_armed;

  pulse_height_histogram_peak_search dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) run_left = $urandom_range(8, 60);
    return $urandom_range(0, 16);
  endfunction

  function automatic in_item_t req_item(logic [1:0] kind, logic [1:0] ch, logic [15:0] adc);
    in_item_t item;
    item.req_type  = kind;
    item.channel   = ch;
    item.adc_value = adc;
    return item;
  endfunction

  task automatic send_req(input in_item_t item);
    int gap;
    gap = pick_gap(tx_run);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (req_stall !== 1'b0);
    peak_check.note_request(item);
  endtask

  // build a triangular peak on every fifth bin, with a few stray hits
  task automatic send_peak(input logic [1:0] ch);
    int center, height, bin, offset, n;
    center = $urandom_range(200, NUM_BINS - 200);
    if ($urandom_range(0, 3) != 0) center = center - center % 5 + 4;
    height = $urandom_range(6, 9);
    for (bin = center - 10 * height; bin <= center + 10 * height; bin += 5) begin
      offset = (bin > center) ? bin - center : center - bin;
      for (n = height - offset / 10; n > 0; n--) begin
        send_req(req_item(REQ_ADD, ch, 16'(bin - 1)));
        if ($urandom_range(0, 15) == 0)
          send_req(req_item(REQ_ADD, ch, 16'($urandom_range(0, NUM_BINS - 1))));
      end
    end
  endtask

  initial begin : result_sink
    int stall_left, open_left, held;
    bit hold_done;
    stall_left = 0;
    open_left  = 0;
    held       = 0;
    hold_done  = 1'b0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_valid === 1'b1 && res_stall === 1'b0) begin
        peak_check.check_result(res_data);
        stall_left = pick_gap(rx_run);
      end else if (stall_left == 0 && open_left == 0) begin
        stall_left = pick_gap(rx_run);
        open_left  = $urandom_range(1, 16);
      end
      if (hold_armed && !hold_done && res_valid === 1'b1) begin
        held++;
        if (held >= HOLD_CYCLES) hold_done = 1'b1;
      end
      if (hold_armed && !hold_done) begin
        res_stall <= 1'b1;
      end else if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
        if (open_left > 0) open_left--;
      end
    end
  end

  initial begin : stimulus
    int         kind, r, clears_sent;
    logic [1:0] ch;
    clears_sent = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_req(req_item(REQ_SEARCH, 2'd0, 16'h0000));
    send_req(req_item(REQ_ADD, 2'd1, 16'h0000));
    send_req(req_item(REQ_ADD, 2'd1, 16'(NUM_BINS - 1)));
    send_req(req_item(REQ_SEARCH, 2'd1, 16'hFFFF));
    send_req(req_item(REQ_ADD, 2'd1, 16'(NUM_BINS - 1)));
    send_req(req_item(REQ_ADD, 2'd1, 16'(NUM_BINS)));
    send_req(req_item(REQ_ADD, 2'd1, 16'hFFFF));
    send_req(req_item(REQ_ADD, 2'd2, 16'h1555));
    send_req(req_item(REQ_ADD, 2'd3, 16'h2AAA));
    send_req(req_item(REQ_NONE, 2'd3, 16'hFFFF));
    send_req(req_item(REQ_SEARCH, 2'd1, 16'h0000));
    send_req(req_item(REQ_SEARCH, 2'd3, 16'h0000));
    send_req(req_item(REQ_CLEAR, 2'd0, 16'h0000));
    send_req(req_item(REQ_SEARCH, 2'd3, 16'h0000));

    // hold results back so the search output backs up into the request side
    hold_armed = 1'b1;
    send_req(req_item(REQ_SEARCH, 2'($urandom_range(0, 3)), 16'($urandom)));
    send_req(req_item(REQ_SEARCH, 2'($urandom_range(0, 3)), 16'($urandom)));

    while (peak_check.n_adds + peak_check.n_searches + peak_check.n_clears < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      ch   = 2'($urandom_range(0, 3));
      if (kind < 8) begin
        send_peak(ch);
      end else if (kind < 21) begin
        send_req(req_item(REQ_SEARCH, ch, 16'($urandom)));
      end else if (kind == 21 && clears_sent < MAX_RANDOM_CLEARS) begin
        send_req(req_item(REQ_CLEAR, ch, 16'($urandom)));
        clears_sent++;
      end else begin
        r = $urandom_range(0, 39);
        if (r == 0) send_req(req_item(REQ_NONE, ch, 16'($urandom)));
        else if (r < 6) send_req(req_item(REQ_ADD, ch, 16'($urandom)));
        else send_req(req_item(REQ_ADD, ch, 16'($urandom_range(0, NUM_BINS - 1))));
      end
    end
    send_req(req_item(REQ_SEARCH, 2'($urandom_range(0, 3)), 16'($urandom)));
    req_valid <= 1'b0;

    while (peak_check.expected_peaks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Run covered %0d counted hits, %0d out-of-range heights, %0d unused requests,",
             peak_check.n_adds, peak_check.n_dropped, peak_check.n_ignored);
    $display("%0d clears and %0d searches giving %0d peak beats and %0d maximum-bin beats",
             peak_check.n_clears, peak_check.n_searches, peak_check.n_peaks,
             peak_check.n_fallbacks);
    if (peak_check.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
